// ===== rtl/core/lee_pkg.sv =====
`timescale 1ns / 1ps
// lee_pkg: shared types, constants and the microcode program of the led effect engine
// used by lee_div, led_effect_engine and the testbench; depends on nothing

package lee_pkg;

    // widths
    localparam int unsigned LEE_POS_W      = 16;
    localparam int unsigned LEE_DIV_W      = 24;
    localparam int unsigned LEE_COUNT_W    = $clog2(LEE_DIV_W + 1);
    localparam int unsigned LEE_UPC_W      = 4;
    localparam int unsigned LEE_ADDR_W     = 5;
    localparam int unsigned LEE_DATA_W     = 32;
    localparam int unsigned LEE_TICK_MS    = 20;

    // reset values and arithmetic constants
    localparam logic [15:0] LEE_PERIOD_RESET = 16'd1000;
    localparam logic [6:0]  LEE_DUTY_RESET   = 7'd50;
    localparam logic [6:0]  LEE_DUTY_MAX     = 7'd100;
    localparam logic [6:0]  LEE_DUTY_DEFAULT = 7'd50;
    localparam logic [15:0] LEE_PERCENT      = 16'd100;
    localparam logic [7:0]  LEE_PHASE_MAX    = 8'd255;
    // x / 255 == (x * 0x8081) >> 23 for every 16-bit x
    localparam logic [15:0] LEE_RECIP_255    = 16'h8081;
    localparam int unsigned LEE_RECIP_SHIFT  = 23;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_EFFECT_MODE  = 3'd0;
    localparam logic [2:0] REG_RED_LEVEL    = 3'd1;
    localparam logic [2:0] REG_GREEN_LEVEL  = 3'd2;
    localparam logic [2:0] REG_BLUE_LEVEL   = 3'd3;
    localparam logic [2:0] REG_PERIOD_MS    = 3'd4;
    localparam logic [2:0] REG_DUTY_PERCENT = 3'd5;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_SOLID   = 2'd1,
        MODE_BLINK   = 2'd2,
        MODE_BREATHE = 2'd3
    } effect_mode_t;

    typedef struct packed {
        logic                 start;
        logic [LEE_DIV_W-1:0] dividend;
        logic [LEE_POS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic [LEE_DIV_W-1:0] quotient;
        logic [LEE_POS_W-1:0] remainder;
    } div_rsp_t;

    typedef enum logic [3:0] {
        OP_NOP         = 4'd0,
        OP_ACCEPT      = 4'd1,
        OP_MOD_WAIT    = 4'd2,
        OP_BLACK       = 4'd3,
        OP_BASE        = 4'd4,
        OP_PHASE_MUL   = 4'd5,
        OP_PHASE_DIV   = 4'd6,
        OP_PHASE_WAIT  = 4'd7,
        OP_SCALE_MUL   = 4'd8,
        OP_SCALE_STORE = 4'd9,
        OP_ONTIME_MUL  = 4'd10,
        OP_BLINK_CMP   = 4'd11,
        OP_EMIT        = 4'd13
    } ucode_op_t;

    typedef enum logic [3:0] {
        C_NEXT       = 4'd0,
        C_ALWAYS     = 4'd1,
        C_NO_INPUT   = 4'd2,
        C_DIV_BUSY   = 4'd3,
        C_MODE_OFF   = 4'd4,
        C_MODE_SOLID = 4'd5,
        C_MODE_BLINK = 4'd6,
        C_HALF_ZERO  = 4'd7,
        C_CHAN_MORE  = 4'd8,
        C_OUT_BUSY   = 4'd9
    } ucode_cond_t;

    typedef struct packed {
        ucode_op_t            op;
        ucode_cond_t          cond;
        logic [LEE_UPC_W-1:0] target;
    } ctrl_word_t;

    // step addresses
    localparam logic [LEE_UPC_W-1:0] UPC_WAIT        = 4'd0;
    localparam logic [LEE_UPC_W-1:0] UPC_MOD_WAIT    = 4'd1;
    localparam logic [LEE_UPC_W-1:0] UPC_BLACK       = 4'd2;
    localparam logic [LEE_UPC_W-1:0] UPC_BASE        = 4'd3;
    localparam logic [LEE_UPC_W-1:0] UPC_DISPATCH    = 4'd4;
    localparam logic [LEE_UPC_W-1:0] UPC_PHASE_MUL   = 4'd5;
    localparam logic [LEE_UPC_W-1:0] UPC_PHASE_DIV   = 4'd6;
    localparam logic [LEE_UPC_W-1:0] UPC_PHASE_WAIT  = 4'd7;
    localparam logic [LEE_UPC_W-1:0] UPC_SCALE_MUL   = 4'd8;
    localparam logic [LEE_UPC_W-1:0] UPC_SCALE_STORE = 4'd9;
    localparam logic [LEE_UPC_W-1:0] UPC_BREATHE_END = 4'd10;
    localparam logic [LEE_UPC_W-1:0] UPC_ONTIME_MUL  = 4'd11;
    localparam logic [LEE_UPC_W-1:0] UPC_BLINK_CMP   = 4'd12;
    localparam logic [LEE_UPC_W-1:0] UPC_SPARE       = 4'd13;
    localparam logic [LEE_UPC_W-1:0] UPC_EMIT        = 4'd14;
    localparam logic [LEE_UPC_W-1:0] UPC_RETURN      = 4'd15;

    function automatic ctrl_word_t ucode_rom(input logic [LEE_UPC_W-1:0] addr);
        ctrl_word_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: UPC_WAIT};
        unique case (addr)
            UPC_WAIT:        w = '{op: OP_ACCEPT,      cond: C_NO_INPUT,   target: UPC_WAIT};
            UPC_MOD_WAIT:    w = '{op: OP_MOD_WAIT,    cond: C_DIV_BUSY,   target: UPC_MOD_WAIT};
            UPC_BLACK:       w = '{op: OP_BLACK,       cond: C_MODE_OFF,   target: UPC_EMIT};
            UPC_BASE:        w = '{op: OP_BASE,        cond: C_MODE_SOLID, target: UPC_EMIT};
            UPC_DISPATCH:    w = '{op: OP_NOP,         cond: C_MODE_BLINK,
                                   target: UPC_ONTIME_MUL};
            UPC_PHASE_MUL:   w = '{op: OP_PHASE_MUL,   cond: C_HALF_ZERO,
                                   target: UPC_SCALE_MUL};
            UPC_PHASE_DIV:   w = '{op: OP_PHASE_DIV,   cond: C_NEXT,       target: UPC_WAIT};
            UPC_PHASE_WAIT:  w = '{op: OP_PHASE_WAIT,  cond: C_DIV_BUSY,
                                   target: UPC_PHASE_WAIT};
            UPC_SCALE_MUL:   w = '{op: OP_SCALE_MUL,   cond: C_NEXT,       target: UPC_WAIT};
            UPC_SCALE_STORE: w = '{op: OP_SCALE_STORE, cond: C_CHAN_MORE,
                                   target: UPC_SCALE_MUL};
            UPC_BREATHE_END: w = '{op: OP_NOP,         cond: C_ALWAYS,     target: UPC_EMIT};
            UPC_ONTIME_MUL:  w = '{op: OP_ONTIME_MUL,  cond: C_NEXT,       target: UPC_WAIT};
            UPC_BLINK_CMP:   w = '{op: OP_BLINK_CMP,   cond: C_ALWAYS,     target: UPC_EMIT};
            // unused step, falls back to idle
            UPC_SPARE:       w = '{op: OP_NOP,         cond: C_ALWAYS,     target: UPC_WAIT};
            UPC_EMIT:        w = '{op: OP_EMIT,        cond: C_OUT_BUSY,   target: UPC_EMIT};
            UPC_RETURN:      w = '{op: OP_NOP,         cond: C_ALWAYS,     target: UPC_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/lee_div.sv =====
`timescale 1ns / 1ps
// lee_div: shared restoring divider, one quotient bit per cycle
// depends on lee_pkg

module lee_div (
    input  logic              clk,
    input  logic              rst_n,
    input  lee_pkg::div_req_t req,
    output lee_pkg::div_rsp_t rsp
);
    import lee_pkg::*;

    logic                   busy_reg, busy_next;
    logic [LEE_COUNT_W-1:0] count_reg, count_next;
    logic [LEE_POS_W-1:0]   rem_reg, rem_next;
    logic [LEE_DIV_W-1:0]   quo_reg, quo_next;
    logic [LEE_POS_W-1:0]   dvs_reg, dvs_next;
    logic [LEE_POS_W:0]     shifted;
    logic [LEE_POS_W+1:0]   diff;

    assign shifted = {rem_reg, quo_reg[LEE_DIV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = LEE_COUNT_W'(LEE_DIV_W);
            rem_next   = '0;
            quo_next   = req.dividend;
            dvs_next   = req.divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits in LEE_POS_W bits
            if (!diff[LEE_POS_W+1])
            begin
                rem_next = diff[LEE_POS_W-1:0];
                quo_next = {quo_reg[LEE_DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[LEE_POS_W-1:0];
                quo_next = {quo_reg[LEE_DIV_W-2:0], 1'b0};
            end
            count_next = count_reg - LEE_COUNT_W'(1);
            if (count_reg == LEE_COUNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== rtl/core/led_effect_engine.sv =====
`timescale 1ns / 1ps
// led_effect_engine: top level, apb registers, microcode sequencer and datapath
// depends on lee_pkg and lee_div
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------
//  tick     | tick_valid / tick_stall    | tick
//  colour   | colour_valid / colour_stall| out_red, out_green, out_blue
//  config   | apb psel/penable/pwrite    | paddr[4:0], pwdata, prdata
//
// one tick transaction at a time; the time from one accepted tick to the next is set by the
// shared divider (one run for the position and one more for the breathe phase) and by the
// three sequential channel scaling steps
// a stalled colour holds the sequencer at the emit step until the output register frees
// the next tick is taken while the previous colour still waits in the output register
// reset clears the registers to their defaults and the time position to zero

module led_effect_engine #(
    parameter int unsigned TICK_MS = lee_pkg::LEE_TICK_MS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // apb
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lee_pkg::LEE_ADDR_W-1:0]  paddr,
    input  logic [lee_pkg::LEE_DATA_W-1:0]  pwdata,
    output logic [lee_pkg::LEE_DATA_W-1:0]  prdata,
    output logic                            pready,
    // tick input
    input  logic                            tick_valid,
    output logic                            tick_stall,
    input  logic                            tick,
    // colour output
    output logic                            colour_valid,
    input  logic                            colour_stall,
    output logic [7:0]                      out_red,
    output logic [7:0]                      out_green,
    output logic [7:0]                      out_blue
);
    import lee_pkg::*;

    // configuration
    effect_mode_t   mode_reg;
    logic [7:0]     red_level_reg;
    logic [7:0]     green_level_reg;
    logic [7:0]     blue_level_reg;
    logic [15:0]    period_reg;
    logic [6:0]     duty_reg;

    // sequencer and datapath
    logic [LEE_UPC_W-1:0] upc_reg, upc_next;
    logic [LEE_POS_W-1:0] pos_reg;
    logic [LEE_DIV_W-1:0] prod_reg;
    logic [7:0]           phase_reg;
    logic [1:0]           chan_reg;
    logic [7:0]           col_reg [3];
    logic                 colour_valid_reg;
    logic [7:0]           out_red_reg, out_green_reg, out_blue_reg;

    ctrl_word_t           cw;
    logic                 cond_true;
    logic                 cfg_write;
    logic                 tick_accept;
    logic                 out_busy;
    logic [LEE_POS_W-1:0] eff_period;
    logic [6:0]           eff_duty;
    logic [LEE_POS_W-1:0] half;
    logic [LEE_POS_W-1:0] ramp_pos;
    logic [7:0]           level_sel;
    logic [31:0]          recip_prod;
    logic [7:0]           phase_sat;
    logic [LEE_DIV_W-1:0] blink_scaled;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    assign cw          = ucode_rom(upc_reg);
    assign cfg_write   = psel && penable && pwrite;
    assign tick_stall  = (cw.op != OP_ACCEPT);
    assign tick_accept = tick_valid && !tick_stall;
    assign out_busy    = colour_valid_reg && colour_stall;
    assign pready      = 1'b1;

    assign eff_period = (period_reg == '0) ? LEE_POS_W'(1) : period_reg;
    assign eff_duty   = (duty_reg > LEE_DUTY_MAX) ? LEE_DUTY_DEFAULT : duty_reg;
    assign half       = eff_period >> 1;
    // rising half uses the position, falling half the distance to the period end
    assign ramp_pos   = (pos_reg < half) ? pos_reg : (eff_period - pos_reg);
    assign phase_sat  = (div_rsp.quotient > LEE_DIV_W'(LEE_PHASE_MAX))
                        ? LEE_PHASE_MAX : div_rsp.quotient[7:0];
    assign recip_prod = 32'(prod_reg[15:0]) * 32'(LEE_RECIP_255);
    // position below period*duty/100 exactly when 100*(position+1) <= period*duty
    assign blink_scaled = (LEE_DIV_W'(pos_reg) + LEE_DIV_W'(1)) * LEE_DIV_W'(LEE_PERCENT);

    always_comb
    begin
        unique case (chan_reg)
            2'd0:    level_sel = red_level_reg;
            2'd1:    level_sel = green_level_reg;
            default: level_sel = blue_level_reg;
        endcase
    end

    // divider requests
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = eff_period;
        unique case (cw.op)
            OP_ACCEPT:
            begin
                div_req.start    = tick_accept;
                div_req.dividend = LEE_DIV_W'(pos_reg) + (tick ? LEE_DIV_W'(TICK_MS) : '0);
                div_req.divisor  = eff_period;
            end
            OP_PHASE_DIV:
            begin
                div_req.start   = 1'b1;
                div_req.divisor = half;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    lee_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // branch conditions
    always_comb
    begin
        unique case (cw.cond)
            C_NEXT:       cond_true = 1'b0;
            C_ALWAYS:     cond_true = 1'b1;
            C_NO_INPUT:   cond_true = !tick_accept;
            C_DIV_BUSY:   cond_true = div_rsp.busy;
            C_MODE_OFF:   cond_true = (mode_reg == MODE_OFF);
            C_MODE_SOLID: cond_true = (mode_reg == MODE_SOLID);
            C_MODE_BLINK: cond_true = (mode_reg == MODE_BLINK);
            C_HALF_ZERO:  cond_true = (half == '0);
            C_CHAN_MORE:  cond_true = (chan_reg != 2'd2);
            C_OUT_BUSY:   cond_true = out_busy;
            default:      cond_true = 1'b0;
        endcase
    end

    assign upc_next = cond_true ? cw.target : (upc_reg + LEE_UPC_W'(1));

    // control state: step counter, time position, output valid, registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg          <= UPC_WAIT;
            pos_reg          <= '0;
            colour_valid_reg <= 1'b0;
            mode_reg         <= MODE_OFF;
            red_level_reg    <= '0;
            green_level_reg  <= '0;
            blue_level_reg   <= '0;
            period_reg       <= LEE_PERIOD_RESET;
            duty_reg         <= LEE_DUTY_RESET;
        end
        else
        begin
            upc_reg <= upc_next;
            if (cw.op == OP_EMIT && !out_busy)
            begin
                colour_valid_reg <= 1'b1;
            end
            else if (colour_valid_reg && !colour_stall)
            begin
                colour_valid_reg <= 1'b0;
            end
            if (cfg_write && (paddr[4:2] <= REG_DUTY_PERCENT))
            begin
                pos_reg <= '0;
            end
            else if (cw.op == OP_MOD_WAIT && !div_rsp.busy)
            begin
                pos_reg <= div_rsp.remainder;
            end
            if (cfg_write)
            begin
                unique case (paddr[4:2])
                    REG_EFFECT_MODE:  mode_reg        <= effect_mode_t'(pwdata[1:0]);
                    REG_RED_LEVEL:    red_level_reg   <= pwdata[7:0];
                    REG_GREEN_LEVEL:  green_level_reg <= pwdata[7:0];
                    REG_BLUE_LEVEL:   blue_level_reg  <= pwdata[7:0];
                    REG_PERIOD_MS:    period_reg      <= pwdata[15:0];
                    REG_DUTY_PERCENT: duty_reg        <= pwdata[6:0];
                    default:          ;
                endcase
            end
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        unique case (cw.op)
            OP_BLACK:
            begin
                col_reg[0] <= '0;
                col_reg[1] <= '0;
                col_reg[2] <= '0;
            end
            OP_BASE:
            begin
                col_reg[0] <= red_level_reg;
                col_reg[1] <= green_level_reg;
                col_reg[2] <= blue_level_reg;
            end
            OP_PHASE_MUL:
            begin
                prod_reg  <= LEE_DIV_W'(ramp_pos) * LEE_DIV_W'(LEE_PHASE_MAX);
                phase_reg <= LEE_PHASE_MAX;
                chan_reg  <= 2'd0;
            end
            OP_PHASE_WAIT:
            begin
                if (!div_rsp.busy)
                begin
                    phase_reg <= phase_sat;
                end
            end
            OP_SCALE_MUL:
            begin
                prod_reg <= LEE_DIV_W'(level_sel) * LEE_DIV_W'(phase_reg);
            end
            OP_SCALE_STORE:
            begin
                col_reg[chan_reg] <= recip_prod[LEE_RECIP_SHIFT+7:LEE_RECIP_SHIFT];
                chan_reg          <= chan_reg + 2'd1;
            end
            OP_ONTIME_MUL:
            begin
                prod_reg <= LEE_DIV_W'(eff_period) * LEE_DIV_W'(eff_duty);
            end
            OP_BLINK_CMP:
            begin
                if (blink_scaled <= prod_reg)
                begin
                    col_reg[0] <= red_level_reg;
                    col_reg[1] <= green_level_reg;
                    col_reg[2] <= blue_level_reg;
                end
                else
                begin
                    col_reg[0] <= '0;
                    col_reg[1] <= '0;
                    col_reg[2] <= '0;
                end
            end
            OP_EMIT:
            begin
                if (!out_busy)
                begin
                    out_red_reg   <= col_reg[0];
                    out_green_reg <= col_reg[1];
                    out_blue_reg  <= col_reg[2];
                end
            end
            default:
            begin
            end
        endcase
    end

    // register read back
    always_comb
    begin
        unique case (paddr[4:2])
            REG_EFFECT_MODE:  prdata = LEE_DATA_W'(mode_reg);
            REG_RED_LEVEL:    prdata = LEE_DATA_W'(red_level_reg);
            REG_GREEN_LEVEL:  prdata = LEE_DATA_W'(green_level_reg);
            REG_BLUE_LEVEL:   prdata = LEE_DATA_W'(blue_level_reg);
            REG_PERIOD_MS:    prdata = LEE_DATA_W'(period_reg);
            REG_DUTY_PERCENT: prdata = LEE_DATA_W'(duty_reg);
            default:          prdata = '0;
        endcase
    end

    assign colour_valid = colour_valid_reg;
    assign out_red      = out_red_reg;
    assign out_green    = out_green_reg;
    assign out_blue     = out_blue_reg;

endmodule

// ===== rtl/core/lee_checker.sv =====
`timescale 1ns / 1ps
// lee_port_checks: port-level checks of the led effect engine, bound to the top level
// depends on led_effect_engine

module lee_port_checks (
    input logic       clk,
    input logic       rst_n,
    input logic       tick_valid,
    input logic       tick_stall,
    input logic       colour_valid,
    input logic       colour_stall,
    input logic [7:0] out_red,
    input logic [7:0] out_green,
    input logic [7:0] out_blue
);

    // one tick transaction in flight: the input closes right after acceptance
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && !tick_stall) |=> tick_stall)
        else $error("tick accepted while previous transaction still in work");

    // a colour never appears the cycle after a tick is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && !tick_stall) |=> !$rose(colour_valid))
        else $error("colour produced without computing it");

    // a fresh colour is presented while the sequencer is still busy
    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(colour_valid) |-> tick_stall)
        else $error("colour appeared while the input was open");

    // stalled colour holds
    a_colour_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (colour_valid && colour_stall) |=>
            (colour_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue)))
        else $error("stalled colour transaction changed");

endmodule

bind led_effect_engine lee_port_checks u_port_checks (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .colour_valid (colour_valid),
    .colour_stall (colour_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue)
);

// ===== sim/lee_checker.sv =====
`timescale 1ns / 1ps
// lee_checker: watches the apb, tick and colour channels of led_effect_engine,
// predicts each colour from its own copy of the registers and position, and compares
// depends on lee_pkg

module lee_checker #(
    parameter int unsigned TICK_MS = lee_pkg::LEE_TICK_MS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [lee_pkg::LEE_ADDR_W-1:0] paddr,
    input  logic [lee_pkg::LEE_DATA_W-1:0] pwdata,
    input  logic                           tick_valid,
    input  logic                           tick_stall,
    input  logic                           tick,
    input  logic                           colour_valid,
    input  logic                           colour_stall,
    input  logic [7:0]                     out_red,
    input  logic [7:0]                     out_green,
    input  logic [7:0]                     out_blue,
    output int                             failures,
    output int                             outstanding
);
    import lee_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } colour_t;

    effect_mode_t      mode_q;
    logic [7:0]        red_q;
    logic [7:0]        green_q;
    logic [7:0]        blue_q;
    logic [15:0]       period_q;
    logic [6:0]        duty_q;
    logic [LEE_POS_W-1:0] position_q;
    colour_t           pending_colours[$];
    colour_t           expected_colour;

    // advances the position by one transaction and returns the colour to show
    function automatic colour_t next_colour(input logic tick_in);
        int unsigned span;
        int unsigned duty;
        int unsigned t;
        int unsigned half;
        int unsigned phase;
        colour_t     c;
        span = (period_q == 16'd0) ? 1 : period_q;
        duty = (duty_q <= LEE_DUTY_MAX) ? duty_q : LEE_DUTY_DEFAULT;
        t = position_q;
        t = tick_in ? (t + TICK_MS) % span : t % span;
        position_q = t[LEE_POS_W-1:0];
        c = '0;
        case (mode_q)
            MODE_SOLID: c = '{red_q, green_q, blue_q};
            MODE_BLINK:
            begin
                if (t < (span * duty) / LEE_PERCENT)
                    c = '{red_q, green_q, blue_q};
            end
            MODE_BREATHE:
            begin
                half = span / 2;
                if (half == 0)
                    phase = LEE_PHASE_MAX;
                else if (t < half)
                    phase = (t * LEE_PHASE_MAX) / half;
                else
                    phase = ((span - t) * LEE_PHASE_MAX) / half;
                // the falling slope can overshoot by one step
                if (phase > LEE_PHASE_MAX)
                    phase = LEE_PHASE_MAX;
                c.red   = 8'((red_q * phase) / LEE_PHASE_MAX);
                c.green = 8'((green_q * phase) / LEE_PHASE_MAX);
                c.blue  = 8'((blue_q * phase) / LEE_PHASE_MAX);
            end
            default: c = '0;
        endcase
        return c;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q      = MODE_OFF;
            red_q       = '0;
            green_q     = '0;
            blue_q      = '0;
            period_q    = LEE_PERIOD_RESET;
            duty_q      = LEE_DUTY_RESET;
            position_q  = '0;
            failures    = 0;
            outstanding = 0;
            pending_colours.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                // writes outside the register list leave the position alone
                case (paddr[LEE_ADDR_W-1:2])
                    REG_EFFECT_MODE:
                    begin
                        mode_q     = effect_mode_t'(pwdata[1:0]);
                        position_q = '0;
                    end
                    REG_RED_LEVEL:
                    begin
                        red_q      = pwdata[7:0];
                        position_q = '0;
                    end
                    REG_GREEN_LEVEL:
                    begin
                        green_q    = pwdata[7:0];
                        position_q = '0;
                    end
                    REG_BLUE_LEVEL:
                    begin
                        blue_q     = pwdata[7:0];
                        position_q = '0;
                    end
                    REG_PERIOD_MS:
                    begin
                        period_q   = pwdata[15:0];
                        position_q = '0;
                    end
                    REG_DUTY_PERCENT:
                    begin
                        duty_q     = pwdata[6:0];
                        position_q = '0;
                    end
                    default: ;
                endcase
            end
            if (tick_valid && !tick_stall)
                pending_colours.push_back(next_colour(tick));
            if (colour_valid && !colour_stall)
            begin
                if (pending_colours.size() == 0)
                begin
                    failures = failures + 1;
                    $display("%0t: unexpected colour transaction, expected none, %s",
                             $time, $sformatf("got r=%0d g=%0d b=%0d",
                                              out_red, out_green, out_blue));
                end
                else
                begin
                    expected_colour = pending_colours.pop_front();
                    if (out_red !== expected_colour.red || out_green !== expected_colour.green ||
                        out_blue !== expected_colour.blue)
                    begin
                        failures = failures + 1;
                        $display("%0t: colour mismatch, expected r=%0d g=%0d b=%0d, %s",
                                 $time, expected_colour.red, expected_colour.green,
                                 expected_colour.blue,
                                 $sformatf("got r=%0d g=%0d b=%0d",
                                           out_red, out_green, out_blue));
                    end
                end
            end
            outstanding = pending_colours.size();
        end
    end

endmodule

// ===== sim/led_effect_engine_test.sv =====
`timescale 1ns / 1ps
// led_effect_engine_test: drives ticks and register writes into led_effect_engine
// with random idling on both channels; depends on lee_pkg, led_effect_engine and lee_checker

module led_effect_engine_test;

    import lee_pkg::*;

    // indexes past the end of the register list
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [LEE_ADDR_W-1:0] paddr;
    logic [LEE_DATA_W-1:0] pwdata;
    logic [LEE_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  tick_valid;
    logic                  tick_stall;
    logic                  tick;
    logic                  colour_valid;
    logic                  colour_stall;
    logic [7:0]            out_red;
    logic [7:0]            out_green;
    logic [7:0]            out_blue;
    int                    failures;
    int                    outstanding;
    int                    send_idle_pct;
    int                    recv_idle_pct;

    led_effect_engine dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .tick_valid(tick_valid), .tick_stall(tick_stall), .tick(tick),
        .colour_valid(colour_valid), .colour_stall(colour_stall),
        .out_red(out_red), .out_green(out_green), .out_blue(out_blue)
    );

    lee_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .tick_valid(tick_valid), .tick_stall(tick_stall), .tick(tick),
        .colour_valid(colour_valid), .colour_stall(colour_stall),
        .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
        .failures(failures), .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("led_effect_engine test failed");
        $finish;
    end

    // receiver side stalls at random, independently of colour_valid
    initial
    begin
        colour_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            colour_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_effect(input logic [31:0] mode, input logic [31:0] red,
                              input logic [31:0] green, input logic [31:0] blue,
                              input logic [31:0] period, input logic [31:0] duty);
        write_reg(REG_EFFECT_MODE, mode);
        write_reg(REG_RED_LEVEL, red);
        write_reg(REG_GREEN_LEVEL, green);
        write_reg(REG_BLUE_LEVEL, blue);
        write_reg(REG_PERIOD_MS, period);
        write_reg(REG_DUTY_PERCENT, duty);
    endtask

    // called and returns at a falling edge; leaves valid high for a following transaction
    task automatic send_tick(input logic value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tick_valid <= 1'b0;
            @(negedge clk);
        end
        tick_valid <= 1'b1;
        tick       <= value;
        do @(posedge clk); while (tick_stall);
        @(negedge clk);
    endtask

    // lowers valid and waits until every colour has come back
    task automatic settle();
        tick_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_level();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'd255;
            default: return $urandom_range(255);
        endcase
    endfunction

    function automatic logic [31:0] pick_period();
        case ($urandom_range(9))
            0:       return ($urandom_range(1) == 0) ? 32'd0 : 32'd65535;
            1:       return $urandom_range(65535);
            2, 3, 4: return $urandom_range(2000, 1);
            default: return $urandom_range(200, 1);
        endcase
    endfunction

    // stray bits above the register width now and then
    function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
        logic [31:0] junk;
        junk = $urandom;
        return ($urandom_range(3) == 0) ? (value | (junk << width)) : value;
    endfunction

    initial
    begin
        logic [31:0] mode;
        logic [31:0] duty;
        int          idle_phase;

        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tick_valid    = 1'b0;
        tick          = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // registers at their reset values
        send_tick(1'b1);
        send_tick(1'b0);

        settle();
        set_effect(MODE_SOLID, 255, 255, 255, 1000, 50);
        send_tick(1'b1);

        settle();
        set_effect(MODE_BLINK, 255, 128, 1, 100, 50);
        repeat (5) send_tick(1'b1);
        send_tick(1'b0);

        settle();
        write_reg(REG_DUTY_PERCENT, 0);
        send_tick(1'b1);
        settle();
        write_reg(REG_DUTY_PERCENT, 100);
        send_tick(1'b1);
        // duty above a hundred falls back to half
        settle();
        write_reg(REG_DUTY_PERCENT, 127);
        repeat (3) send_tick(1'b1);
        settle();
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_HI, 32'h0000_0001);
        send_tick(1'b1);

        // zero period counts as one
        settle();
        set_effect(MODE_BLINK, 0, 255, 0, 0, 100);
        send_tick(1'b1);

        // breathe with no half-period, then with an overshooting falling slope
        settle();
        set_effect(MODE_BREATHE, 255, 200, 7, 1, 50);
        send_tick(1'b1);
        settle();
        write_reg(REG_PERIOD_MS, 41);
        repeat (2) send_tick(1'b1);
        settle();
        write_reg(REG_PERIOD_MS, 65535);
        repeat (2) send_tick(1'b1);
        settle();
        write_reg(REG_EFFECT_MODE, MODE_OFF);
        send_tick(1'b1);

        for (idle_phase = 0; idle_phase < 3; idle_phase++)
        begin
            case (idle_phase)
                0:       begin send_idle_pct = 27; recv_idle_pct = 64; end
                1:       begin send_idle_pct = 64; recv_idle_pct = 27; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            repeat (6)
            begin
                settle();
                // blink and breathe carry most of the arithmetic
                mode = ($urandom_range(3) == 0) ? $urandom_range(MODE_SOLID, MODE_OFF)
                                                : $urandom_range(MODE_BREATHE, MODE_BLINK);
                duty = ($urandom_range(4) == 0) ? $urandom_range(127) : $urandom_range(100);
                set_effect(with_junk(mode, 2), with_junk(pick_level(), 8),
                           with_junk(pick_level(), 8), with_junk(pick_level(), 8),
                           with_junk(pick_period(), 16), with_junk(duty, 7));
                repeat ($urandom_range(52, 30))
                    send_tick($urandom_range(9) != 0);
            end
        end

        tick_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (failures == 0 && outstanding == 0)
            $display("led_effect_engine test passed");
        else
            $display("led_effect_engine test failed");
        $finish;
    end

endmodule
